// File: rtl/sle_pkg.sv
// shared types and constants for the spiral bit extractor
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_INDEX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SMP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_BYTES  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 3'd7;

  localparam int ADDR_W = 26;

  // op codes of an input item
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // what one accepted item turns into for the result sequencer
  typedef struct packed {
    logic        emit_valid;
    logic [7:0]  emit_byte;
    logic [3:0]  flush_cnt;    // window bytes to flush, oldest at the top
    logic [63:0] flush_bytes;  // newest byte in bits 7:0
    logic        found;
    logic        done;
  } sle_rec_t;

endpackage
`default_nettype wire

// File: rtl/spiral_lsb_message_extractor.sv
// top level of the spiral low-bit message extractor
// usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index (register number) and
//   cfg_data; cfg_ready is always high. spiral limits take effect at the next
//   restart item; write registers only while the block is idle.
//   in channel: in_valid/in_ready with op and sample. op restart rewinds the
//   spiral to the origin; op sample hands in the value read at the address
//   given by the last result item.
//   out channel: out_valid/out_ready with next_address, byte_valid,
//   byte_value, last, found and done_res; each input item yields one or
//   more result items, the final one marked by last.
// timing:
//   front end takes one item per cycle while in_ready is high, updates
//   spiral, bit packer and terminator window in that cycle and queues one
//   record (4-entry queue); results come out of the queue through the
//   sequencer's current-record register. rate is one item per cycle while
//   each item yields one result and out_ready is high; an item with more
//   results holds the sequencer until all are taken, the front end running
//   on until the queue fills. in_ready drops for one cycle after a cfg write.
// reset: synchronous, clears the scan to the origin and empties the queue;
//   registers return to a 1x1 image, stride 1, one channel, one bit, magic
//   length 1 with magic byte zero.
`timescale 1ns / 1ps
`default_nettype none
module spiral_lsb_message_extractor
  import sle_pkg::*;
#(
  parameter int MAX_DIM   = 4096,
  parameter int MAGIC_MAX = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 op,
  input  wire logic [7:0]           sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_W-1:0]         next_address,
  output logic                      byte_valid,
  output logic [7:0]                byte_value,
  output logic                      last,
  output logic                      found,
  output logic                      done_res
);

  localparam int PW  = $clog2(MAX_DIM);
  localparam int PCW = 2 * PW + 2;
  localparam int QW  = $bits(sle_rec_t) + 2 * PW;

  // configuration registers
  logic [12:0] image_width, image_height;
  logic [13:0] row_stride;
  logic [2:0]  channel_count;
  logic [1:0]  channel_index;
  logic [3:0]  bits_per_sample;
  logic [63:0] magic_bytes;
  logic [3:0]  magic_length;
  logic        cfg_hold;   // lets total pixel count settle after a write
  logic [PCW-1:0] total;

  logic [PW:0] dim_w, dim_h;
  logic [3:0]  nb, mlen;

  logic        take, q_full, q_valid, q_pop;
  sle_rec_t    f_rec, q_rec;
  logic [PW-1:0] f_x, f_y, q_x, q_y;
  logic [QW-1:0] q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !cfg_hold;
  assign take      = in_valid && in_ready;

  // clamp dimensions into 1..MAX_DIM, bits into 1..8, magic length into 1..MAGIC_MAX
  always_comb begin
    if (image_width == 13'd0) dim_w = (PW+1)'(1);
    else if (32'(image_width) > 32'(MAX_DIM)) dim_w = (PW+1)'(MAX_DIM);
    else dim_w = (PW+1)'(image_width);
    if (image_height == 13'd0) dim_h = (PW+1)'(1);
    else if (32'(image_height) > 32'(MAX_DIM)) dim_h = (PW+1)'(MAX_DIM);
    else dim_h = (PW+1)'(image_height);
    if (bits_per_sample == 4'd0) nb = 4'd1;
    else if (bits_per_sample > 4'd8) nb = 4'd8;
    else nb = bits_per_sample;
    if (magic_length == 4'd0) mlen = 4'd1;
    else if (magic_length > 4'(MAGIC_MAX)) mlen = 4'(MAGIC_MAX);
    else mlen = magic_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1;
      image_height <= 13'd1;
      row_stride <= 14'd1;
      channel_count <= 3'd1;
      channel_index <= 2'd0;
      bits_per_sample <= 4'd1;
      magic_bytes <= 64'd0;
      magic_length <= 4'd1;
      cfg_hold <= 1'b0;
      total <= PCW'(1);
    end else begin
      cfg_hold <= cfg_valid;
      total <= PCW'(dim_w) * PCW'(dim_h);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width <= cfg_data[12:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
          CFG_ROW_STRIDE:   row_stride <= cfg_data[13:0];
          CFG_CHAN_COUNT:   channel_count <= cfg_data[2:0];
          CFG_CHAN_INDEX:   channel_index <= cfg_data[1:0];
          CFG_BITS_PER_SMP: bits_per_sample <= cfg_data[3:0];
          CFG_MAGIC_BYTES:  magic_bytes <= cfg_data;
          CFG_MAGIC_LENGTH: magic_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // scan front end
  sle_front #(
    .PW(PW), .PCW(PCW), .MAGIC_MAX(MAGIC_MAX)
  ) u_front (
    .clk(clk), .rst(rst), .take(take), .op(op), .sample(sample),
    .dim_w(dim_w), .dim_h(dim_h), .total(total), .nb(nb), .mlen(mlen),
    .magic(magic_bytes), .rec(f_rec), .rec_x(f_x), .rec_y(f_y)
  );

  // record queue
  sle_fifo #(.WIDTH(QW)) u_fifo (
    .clk(clk), .rst(rst), .push(take), .push_data({f_y, f_x, f_rec}),
    .full(q_full), .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  assign q_rec = q_head[$bits(sle_rec_t)-1:0];
  assign q_x   = q_head[$bits(sle_rec_t) +: PW];
  assign q_y   = q_head[$bits(sle_rec_t) + PW +: PW];

  // result sequencer and address generation
  sle_back #(.PW(PW)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_rec(q_rec), .q_x(q_x), .q_y(q_y),
    .pop(q_pop), .row_stride(row_stride), .channel_count(channel_count),
    .channel_index(channel_index), .out_valid(out_valid), .out_ready(out_ready),
    .next_address(next_address), .byte_valid(byte_valid), .byte_value(byte_value),
    .last(last), .found(found), .done_res(done_res)
  );

endmodule
`default_nettype wire

// File: rtl/sle_front.sv
// scan front end: spiral walk, bit unpacking and terminator window
`timescale 1ns / 1ps
`default_nettype none
module sle_front
  import sle_pkg::*;
#(
  parameter int PW        = 12,
  parameter int PCW       = 26,
  parameter int MAGIC_MAX = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic           op,
  input  wire logic [7:0]     sample,
  input  wire logic [PW:0]    dim_w,
  input  wire logic [PW:0]    dim_h,
  input  wire logic [PCW-1:0] total,
  input  wire logic [3:0]     nb,
  input  wire logic [3:0]     mlen,
  input  wire logic [63:0]    magic,
  output sle_rec_t            rec,
  output logic [PW-1:0]       rec_x,
  output logic [PW-1:0]       rec_y
);

  localparam int WW = MAGIC_MAX * 8;

  logic [PW-1:0]  pos_x, pos_y, left_bound, top_bound;
  logic [PW:0]    right_limit, bottom_limit;
  logic           moving_horizontal, moving_forward, finished;
  logic [PCW-1:0] pixels_visited;
  logic [7:0]     partial_byte;
  logic [2:0]     bit_position;
  logic [WW-1:0]  byte_window;
  logic [3:0]     window_fill;

  logic [PW-1:0]  pos_x_next, pos_y_next, left_bound_next, top_bound_next;
  logic [PW:0]    right_limit_next, bottom_limit_next;
  logic           moving_horizontal_next, moving_forward_next, finished_next;
  logic [PCW-1:0] pixels_visited_next;
  logic [7:0]     partial_byte_next;
  logic [2:0]     bit_position_next;
  logic [WW-1:0]  byte_window_next;
  logic [3:0]     window_fill_next;

  always_comb begin
    logic       got;
    logic [7:0] byt;
    logic       match;
    logic [3:0] need;
    logic [WW-1:0] oldest_sh;
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    left_bound_next = left_bound;
    top_bound_next = top_bound;
    right_limit_next = right_limit;
    bottom_limit_next = bottom_limit;
    moving_horizontal_next = moving_horizontal;
    moving_forward_next = moving_forward;
    finished_next = finished;
    pixels_visited_next = pixels_visited;
    partial_byte_next = partial_byte;
    bit_position_next = bit_position;
    byte_window_next = byte_window;
    window_fill_next = window_fill;
    rec = '0;
    got = 1'b0;
    byt = 8'd0;
    match = 1'b0;
    need = mlen - 4'd1;
    oldest_sh = '0;
    if (op == OP_RESTART) begin
      pos_x_next = '0;
      pos_y_next = '0;
      left_bound_next = '0;
      top_bound_next = '0;
      right_limit_next = dim_w;
      bottom_limit_next = dim_h;
      moving_horizontal_next = 1'b1;
      moving_forward_next = 1'b1;
      finished_next = 1'b0;
      pixels_visited_next = '0;
      partial_byte_next = 8'd0;
      bit_position_next = 3'd7;
      byte_window_next = '0;
      window_fill_next = 4'd0;
    end else if (finished) begin
      rec.done = 1'b1;
    end else begin
      // unpack the used low bits, msb first; at most one byte completes
      for (int id = 7; id >= 0; id--) begin
        if (4'(id) < nb) begin
          partial_byte_next = partial_byte_next |
                              (8'(sample[id]) << bit_position_next);
          if (bit_position_next == 3'd0) begin
            got = 1'b1;
            byt = partial_byte_next;
            partial_byte_next = 8'd0;
            bit_position_next = 3'd7;
          end else begin
            bit_position_next = bit_position_next - 3'd1;
          end
        end
      end
      // newest byte against magic byte 0, window byte j against magic byte j+1
      if (got && window_fill >= need && byt == magic[7:0]) begin
        match = 1'b1;
        for (int j = 0; j < MAGIC_MAX - 1; j++) begin
          if (4'(j) < need && byte_window[8*j +: 8] != magic[8*(j+1) +: 8])
            match = 1'b0;
        end
      end
      if (got && !match) begin
        if (window_fill >= need || window_fill >= 4'(MAGIC_MAX - 1)) begin
          rec.emit_valid = 1'b1;
          if (window_fill == 4'd0) begin
            rec.emit_byte = byt;
          end else begin
            oldest_sh = byte_window >> (8 * (window_fill - 4'd1));
            rec.emit_byte = oldest_sh[7:0];
            byte_window_next = (byte_window << 8) | WW'(byt);
          end
        end else begin
          byte_window_next = (byte_window << 8) | WW'(byt);
          window_fill_next = window_fill + 4'd1;
        end
      end
      pixels_visited_next = pixels_visited + PCW'(1);
      if (match) begin
        finished_next = 1'b1;
        window_fill_next = 4'd0;
        rec.emit_valid = 1'b0;
        rec.found = 1'b1;
        rec.done = 1'b1;
      end else if (pixels_visited_next >= total) begin
        finished_next = 1'b1;
        rec.done = 1'b1;
        rec.flush_cnt = window_fill_next;
        rec.flush_bytes = 64'(byte_window_next);
        window_fill_next = 4'd0;
      end else if (moving_horizontal && moving_forward) begin
        if ({1'b0, pos_x} + (PW+1)'(1) < right_limit) begin
          pos_x_next = pos_x + PW'(1);
        end else begin
          top_bound_next = top_bound + PW'(1);
          moving_horizontal_next = 1'b0;
          pos_y_next = pos_y + PW'(1);
        end
      end else if (!moving_horizontal && moving_forward) begin
        if ({1'b0, pos_y} + (PW+1)'(1) < bottom_limit) begin
          pos_y_next = pos_y + PW'(1);
        end else begin
          right_limit_next = right_limit - (PW+1)'(1);
          moving_horizontal_next = 1'b1;
          moving_forward_next = 1'b0;
          pos_x_next = pos_x - PW'(1);
        end
      end else if (moving_horizontal) begin
        if (pos_x > left_bound) begin
          pos_x_next = pos_x - PW'(1);
        end else begin
          bottom_limit_next = bottom_limit - (PW+1)'(1);
          moving_horizontal_next = 1'b0;
          pos_y_next = pos_y - PW'(1);
        end
      end else begin
        if (pos_y > top_bound) begin
          pos_y_next = pos_y - PW'(1);
        end else begin
          left_bound_next = left_bound + PW'(1);
          moving_horizontal_next = 1'b1;
          moving_forward_next = 1'b1;
          pos_x_next = pos_x + PW'(1);
        end
      end
    end
    rec_x = pos_x_next;
    rec_y = pos_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      left_bound <= '0;
      top_bound <= '0;
      right_limit <= (PW+1)'(1);
      bottom_limit <= (PW+1)'(1);
      moving_horizontal <= 1'b1;
      moving_forward <= 1'b1;
      finished <= 1'b0;
      pixels_visited <= '0;
      partial_byte <= 8'd0;
      bit_position <= 3'd7;
      byte_window <= '0;
      window_fill <= 4'd0;
    end else if (take) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      left_bound <= left_bound_next;
      top_bound <= top_bound_next;
      right_limit <= right_limit_next;
      bottom_limit <= bottom_limit_next;
      moving_horizontal <= moving_horizontal_next;
      moving_forward <= moving_forward_next;
      finished <= finished_next;
      pixels_visited <= pixels_visited_next;
      partial_byte <= partial_byte_next;
      bit_position <= bit_position_next;
      byte_window <= byte_window_next;
      window_fill <= window_fill_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sle_fifo.sv
// small register queue between front end and result sequencer
`timescale 1ns / 1ps
`default_nettype none
module sle_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/sle_back.sv
// result sequencer: expands one queued record into its result items
`timescale 1ns / 1ps
`default_nettype none
module sle_back
  import sle_pkg::*;
#(
  parameter int PW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire sle_rec_t      q_rec,
  input  wire logic [PW-1:0] q_x,
  input  wire logic [PW-1:0] q_y,
  output logic               pop,
  input  wire logic [13:0]   row_stride,
  input  wire logic [2:0]    channel_count,
  input  wire logic [1:0]    channel_index,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [ADDR_W-1:0]  next_address,
  output logic               byte_valid,
  output logic [7:0]         byte_value,
  output logic               last,
  output logic               found,
  output logic               done_res
);

  localparam int AW = (PW + 16 > ADDR_W) ? PW + 16 : ADDR_W;

  logic          cur_valid;
  sle_rec_t      cur_rec;
  logic [PW-1:0] cur_x, cur_y;
  logic [3:0]    idx;

  logic [3:0]    nres;
  logic          final_item;
  logic [3:0]    slot;
  logic [63:0]   flush_sh;
  logic [AW-1:0] addr_full;

  assign nres       = 4'(cur_rec.emit_valid) + cur_rec.flush_cnt;
  assign final_item = (nres == 4'd0) || (idx == nres - 4'd1);
  assign slot       = cur_rec.flush_cnt - 4'd1 - (idx - 4'(cur_rec.emit_valid));
  assign flush_sh   = cur_rec.flush_bytes >> (8 * slot);
  assign pop        = q_valid && (!cur_valid || (out_ready && final_item));

  assign addr_full = AW'(cur_y) * AW'(row_stride) + AW'(cur_x) * AW'(channel_count)
                   + AW'(channel_index);

  assign out_valid    = cur_valid;
  assign next_address = addr_full[ADDR_W-1:0];
  assign byte_valid   = (nres != 4'd0);
  assign last         = final_item;
  assign found        = cur_rec.found && final_item;
  assign done_res     = cur_rec.done && final_item;

  always_comb begin
    if (nres == 4'd0) begin
      byte_value = 8'd0;
    end else if (cur_rec.emit_valid && idx == 4'd0) begin
      byte_value = cur_rec.emit_byte;
    end else begin
      byte_value = flush_sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_rec <= q_rec;
      cur_x <= q_x;
      cur_y <= q_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 4'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx <= 4'd0;
    end else if (cur_valid && out_ready) begin
      if (final_item) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_mid_record: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !final_item |=> cur_valid) else $error("record dropped early");
  a_found_no_bytes: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur_rec.found |-> nres == 4'd0) else $error("match record carries bytes");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !out_ready |=> $stable(idx) && cur_valid) else $error("stall lost item");
`endif

endmodule
`default_nettype wire

// File: tb/spiral_lsb_message_extractor_tb.sv
// self-checking testbench for the spiral low-bit message extractor
`timescale 1ns / 1ps
module spiral_lsb_message_extractor_tb;
  import sle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  // one result item as seen on the output channel
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              bvalid;
    logic [7:0]        bvalue;
    logic              lst;
    logic              fnd;
    logic              dn;
  } res_t;

  // one row of the directed plan: a register write or an input item
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
    logic                 opv;
    logic [7:0]           smp;
    bit                   typed;
    res_t                 want;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready, op;
  logic [7:0] sample;
  logic out_valid, out_ready;
  logic [ADDR_W-1:0] next_address;
  logic byte_valid, last, found, done_res;
  logic [7:0] byte_value;

  spiral_lsb_message_extractor DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .next_address(next_address),
    .byte_valid(byte_valid), .byte_value(byte_value), .last(last), .found(found),
    .done_res(done_res)
  );

  res_t pending_results[$];
  row_t plan[$];
  int   errors = 0;
  int   cycles = 0;
  bit   gaps_on = 1;
  bit   stall_on = 1;
  bit   hold_long = 0;

  // mirror of the register file
  logic [12:0] r_width, r_height;
  logic [13:0] r_stride;
  logic [2:0]  r_ccount;
  logic [1:0]  r_cidx;
  logic [3:0]  r_bits;
  logic [63:0] r_magic;
  logic [3:0]  r_mlen;

  // mirror of the scan state
  int unsigned px, py, lb, tb, rl, bl;
  bit          mh, mf, fin;
  int unsigned visited;
  int          bitpos, fill;
  logic [7:0]  partial;
  logic [7:0]  win [8];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic int unsigned magic_len();
    if (r_mlen == 0) return 1;
    if (r_mlen > 8) return 8;
    return r_mlen;
  endfunction

  function automatic logic [7:0] magic_at(input int unsigned i, input int unsigned len);
    return 8'(r_magic >> (8 * (len - 1 - i)));
  endfunction

  function automatic logic [ADDR_W-1:0] addr_now();
    logic [63:0] a;
    a = 64'(py) * 64'(r_stride) + 64'(px) * 64'(r_ccount) + 64'(r_cidx);
    return a[ADDR_W-1:0];
  endfunction

  task automatic rewind_scan();
    px = 0; py = 0; lb = 0; tb = 0;
    rl = clamp_dim(r_width);
    bl = clamp_dim(r_height);
    mh = 1; mf = 1; visited = 0; partial = 0; bitpos = 7;
    for (int i = 0; i < 8; i++) win[i] = 0;
    fill = 0; fin = 0;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    case (idx)
      CFG_IMAGE_WIDTH:  r_width  = v[12:0];
      CFG_IMAGE_HEIGHT: r_height = v[12:0];
      CFG_ROW_STRIDE:   r_stride = v[13:0];
      CFG_CHAN_COUNT:   r_ccount = v[2:0];
      CFG_CHAN_INDEX:   r_cidx   = v[1:0];
      CFG_BITS_PER_SMP: r_bits   = v[3:0];
      CFG_MAGIC_BYTES:  r_magic  = v;
      CFG_MAGIC_LENGTH: r_mlen   = v[3:0];
      default: ;
    endcase
  endtask

  // one step of the clockwise inward spiral
  task automatic spiral_step();
    if (mh && mf) begin
      if (px + 1 < rl) px++;
      else begin tb++; mh = 0; py++; end
    end else if (!mh && mf) begin
      if (py + 1 < bl) py++;
      else begin rl--; mh = 1; mf = 0; px--; end
    end else if (mh) begin
      if (px > lb) px--;
      else begin bl--; mh = 0; py--; end
    end else begin
      if (py > tb) py--;
      else begin lb++; mh = 1; mf = 1; px++; end
    end
  endtask

  // push a finished byte through the terminator window
  task automatic window_byte(input logic [7:0] b, output bit hit, output bit emitted,
                             output logic [7:0] eb);
    int unsigned len, need;
    bit eq;
    len = magic_len();
    need = len - 1;
    hit = 0; emitted = 0; eb = 0;
    if (fill >= need) begin
      eq = (magic_at(need, len) == b);
      for (int i = 0; i < need; i++)
        if (win[fill - need + i] != magic_at(i, len)) eq = 0;
      if (eq) begin
        fill = 0;
        hit = 1;
        return;
      end
    end
    if (fill >= need || fill >= 7) begin
      if (fill == 0) begin
        emitted = 1; eb = b;
        return;
      end
      emitted = 1; eb = win[0];
      for (int i = 0; i < fill - 1; i++) win[i] = win[i + 1];
      fill--;
    end
    if (fill < 8) begin
      win[fill] = b;
      fill++;
    end
  endtask

  function automatic res_t mk(input logic [ADDR_W-1:0] a, input logic bv, input logic [7:0] v,
                              input logic l, input logic f, input logic d);
    res_t r;
    r.addr = a; r.bvalid = bv; r.bvalue = bv ? v : 8'h00; r.lst = l; r.fnd = f; r.dn = d;
    return r;
  endfunction

  // expected results for one accepted item
  task automatic predict_results(input logic opv, input logic [7:0] s);
    int unsigned nb;
    bit hit, emitted;
    logic [7:0] eb;
    logic [ADDR_W-1:0] a;
    res_t batch[$];
    hit = 0; emitted = 0; eb = 0;
    if (opv == OP_RESTART) begin
      rewind_scan();
      pending_results.push_back(mk(addr_now(), 0, 0, 1, 0, 0));
      return;
    end
    if (fin) begin
      pending_results.push_back(mk(addr_now(), 0, 0, 1, 0, 1));
      return;
    end
    nb = (r_bits == 0) ? 1 : (r_bits > 8) ? 8 : r_bits;
    for (int id = nb; id > 0 && !hit; id--) begin
      partial = partial | (8'(s[id-1]) << bitpos);
      if (bitpos == 0) begin
        window_byte(partial, hit, emitted, eb);
        partial = 0;
        bitpos = 7;
      end else begin
        bitpos--;
      end
    end
    visited++;
    if (hit) begin
      fin = 1;
      pending_results.push_back(mk(addr_now(), 0, 0, 1, 1, 1));
      return;
    end
    if (visited >= clamp_dim(r_width) * clamp_dim(r_height)) fin = 1;
    else spiral_step();
    a = addr_now();
    if (emitted) batch.push_back(mk(a, 1, eb, 0, 0, 0));
    if (fin) begin
      for (int i = 0; i < fill; i++) batch.push_back(mk(a, 1, win[i], 0, 0, 0));
      fill = 0;
    end
    if (batch.size() == 0) batch.push_back(mk(a, 0, 0, 1, 0, fin));
    batch[batch.size() - 1].lst = 1;
    batch[batch.size() - 1].dn = fin;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", next_address, 0);
      end else begin
        res_t w;
        w = pending_results.pop_front();
        if (next_address !== w.addr) report("next_address", next_address, w.addr);
        if (byte_valid !== w.bvalid) report("byte_valid", byte_valid, w.bvalid);
        if (byte_value !== w.bvalue) report("byte_value", byte_value, w.bvalue);
        if (last !== w.lst) report("last", last, w.lst);
        if (found !== w.fnd) report("found", found, w.fnd);
        if (done_res !== w.dn) report("done_res", done_res, w.dn);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready <= 0;
    forever begin
      if (hold_long) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // offer one input item and wait for it to be taken
  task automatic send_item(input logic opv, input logic [7:0] s);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    op <= opv;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_results(opv, s);
  endtask

  // register write; valid stays up for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, v);
  endtask

  // drop valids and wait until every expected item is back
  task automatic drain();
    in_valid <= 0;
    cfg_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    row_t r;
    r = '{default: 0};
    r.is_cfg = 1; r.idx = idx; r.data = v;
    plan.push_back(r);
  endtask

  task automatic add_item(input logic opv, input logic [7:0] s);
    row_t r;
    r = '{default: 0};
    r.opv = opv; r.smp = s;
    plan.push_back(r);
  endtask

  task automatic add_typed(input logic opv, input logic [7:0] s, input res_t w);
    row_t r;
    r = '{default: 0};
    r.opv = opv; r.smp = s; r.typed = 1; r.want = w;
    plan.push_back(r);
  endtask

  // random data with only the field bits chosen, garbage above
  function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    return ({$urandom, $urandom} & ~m) | (v & m);
  endfunction

  task automatic random_config(input bit geom_extreme);
    int unsigned w, h;
    w = geom_extreme ? $urandom_range(0, 8191) % 40 : $urandom_range(1, 6);
    h = $urandom_range(1, 6);
    write_reg(CFG_IMAGE_WIDTH, with_junk(w, 13));
    write_reg(CFG_IMAGE_HEIGHT, with_junk(h, 13));
    write_reg(CFG_ROW_STRIDE, with_junk($urandom_range(0, 16383), 14));
    write_reg(CFG_CHAN_COUNT, with_junk($urandom_range(0, 7), 3));
    write_reg(CFG_CHAN_INDEX, with_junk($urandom_range(0, 3), 2));
    write_reg(CFG_BITS_PER_SMP, with_junk($urandom_range(0, 3) == 0 ?
                                          $urandom_range(0, 15) : $urandom_range(1, 8), 4));
    write_reg(CFG_MAGIC_BYTES, {$urandom, $urandom});
    write_reg(CFG_MAGIC_LENGTH, with_junk($urandom_range(0, 4) == 0 ?
                                          $urandom_range(0, 15) : $urandom_range(1, 3), 4));
  endtask

  // message bytes then the terminator, spread over samples with random upper bits
  task automatic send_message(output int sent);
    bit bits_q[$];
    int unsigned nb, len, nmsg;
    logic [7:0] b, s;
    sent = 0;
    nb = (r_bits == 0) ? 1 : (r_bits > 8) ? 8 : r_bits;
    len = magic_len();
    nmsg = $urandom_range(0, 6);
    for (int i = 0; i < nmsg + len; i++) begin
      b = (i < nmsg) ? 8'($urandom) : magic_at(i - nmsg, len);
      for (int k = 7; k >= 0; k--) bits_q.push_back(b[k]);
    end
    while (bits_q.size() != 0) begin
      s = 8'($urandom);
      for (int k = nb - 1; k >= 0; k--)
        if (bits_q.size() != 0) s[k] = bits_q.pop_front();
      send_item(OP_SAMPLE, s);
      sent++;
    end
  endtask

  initial begin
    int rand_items, sent, phase, n;
    rst <= 1;
    cfg_valid <= 0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 0; op <= OP_SAMPLE; sample <= '0;
    r_width = 1; r_height = 1; r_stride = 1; r_ccount = 1;
    r_cidx = 0; r_bits = 1; r_magic = 0; r_mlen = 1;
    rewind_scan();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset: 1x1 image, one bit, so the first sample ends the scan
    add_typed(OP_SAMPLE, 8'h00, mk(0, 0, 0, 1, 0, 1));
    add_typed(OP_SAMPLE, 8'hFF, mk(0, 0, 0, 1, 0, 1));
    add_typed(OP_RESTART, 8'h00, mk(0, 0, 0, 1, 0, 0));
    // widest stride and channel index, four channels, full byte per sample, terminator 0xff
    add_cfg(CFG_IMAGE_WIDTH, 2);
    add_cfg(CFG_IMAGE_HEIGHT, 2);
    add_cfg(CFG_ROW_STRIDE, 16383);
    add_cfg(CFG_CHAN_COUNT, 4);
    add_cfg(CFG_CHAN_INDEX, 3);
    add_cfg(CFG_BITS_PER_SMP, 8);
    add_cfg(CFG_MAGIC_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(CFG_MAGIC_LENGTH, 1);
    add_typed(OP_RESTART, 8'h00, mk(3, 0, 0, 1, 0, 0));
    add_typed(OP_SAMPLE, 8'hFF, mk(3, 0, 0, 1, 1, 1));
    add_typed(OP_SAMPLE, 8'h00, mk(3, 0, 0, 1, 0, 1));
    add_typed(OP_RESTART, 8'h00, mk(3, 0, 0, 1, 0, 0));
    add_typed(OP_SAMPLE, 8'h00, mk(7, 1, 8'h00, 1, 0, 0));
    add_item(OP_SAMPLE, 8'hA5);
    add_item(OP_SAMPLE, 8'h5A);
    add_item(OP_SAMPLE, 8'hFE);
    // out-of-range codes: zero bits, zero length, zero width, oversize height
    add_cfg(CFG_BITS_PER_SMP, 0);
    add_cfg(CFG_MAGIC_LENGTH, 0);
    add_cfg(CFG_MAGIC_BYTES, 0);
    add_cfg(CFG_IMAGE_WIDTH, 0);
    add_cfg(CFG_IMAGE_HEIGHT, 8191);
    add_item(OP_RESTART, 8'h00);
    for (int i = 0; i < 4; i++) add_item(OP_SAMPLE, 8'h01 << i);
    // oversize bits and length, widest image
    add_cfg(CFG_BITS_PER_SMP, 15);
    add_cfg(CFG_MAGIC_LENGTH, 15);
    add_cfg(CFG_MAGIC_BYTES, 64'h0123_4567_89AB_CDEF);
    add_cfg(CFG_IMAGE_WIDTH, 4096);
    add_cfg(CFG_IMAGE_HEIGHT, 1);
    add_item(OP_RESTART, 8'h00);
    for (int i = 0; i < 10; i++) add_item(OP_SAMPLE, 8'h11 * i);
    // terminator length shrinks mid scan, older window bytes drain
    add_cfg(CFG_MAGIC_LENGTH, 3);
    for (int i = 0; i < 3; i++) add_item(OP_SAMPLE, 8'h89 + i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (i > 0 && plan[i-1].is_cfg) cfg_valid <= 0;
        send_item(plan[i].opv, plan[i].smp);
        if (plan[i].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(plan[i].want);
        end
      end
    end
    drain();

    // random phases: mostly well-formed messages, some noise
    rand_items = 0;
    phase = 0;
    while (rand_items < 250) begin
      if (rand_items > 200) begin
        gaps_on = 0;
        stall_on = 0;
      end
      random_config(phase % 7 == 3);
      cfg_valid <= 0;
      send_item(OP_RESTART, 8'h00);
      rand_items++;
      if (phase == 2) hold_long = 1;
      // the long hold-off phase always sends enough items to fill the queue
      if (phase != 2 && $urandom_range(0, 3) != 0) begin
        send_message(sent);
        rand_items += sent;
        n = $urandom_range(0, 2);
      end else begin
        n = $urandom_range(6, 12);
        for (int i = 0; i < n; i++) send_item(OP_SAMPLE, 8'($urandom));
        rand_items += n;
        // new terminator length while the scan is still going
        drain();
        write_reg(CFG_MAGIC_LENGTH, with_junk($urandom_range(0, 9), 4));
        cfg_valid <= 0;
        n = $urandom_range(6, 12);
      end
      for (int i = 0; i < n; i++)
        send_item($urandom_range(0, 7) == 0 ? OP_RESTART : OP_SAMPLE, 8'($urandom));
      rand_items += n;
      drain();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
